>>> hdl/dcf_pkg.sv
// Shared definitions for the directed cycle finder: operation and status codes,
// the result record and the edge store command group. No dependencies.
`default_nettype none

package dcf_pkg;

    localparam int FIELD_W = 9;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_RUN    = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_NONE   = 2'd1;
    localparam logic [1:0] STATUS_REJECT = 2'd2;
    localparam logic [1:0] STATUS_EMPTY  = 2'd3;

    typedef struct packed {
        logic               last;
        logic [FIELD_W-1:0] node;
        logic [FIELD_W-1:0] cycle_length;
        logic [1:0]         status;
    } dcf_result_t;

    typedef struct packed {
        logic tail_rd;
        logic head_rd;
        logic edge_rd;
        logic commit;
    } dcf_store_cmd_t;

endpackage

`default_nettype wire

>>> hdl/dcf_graph_store.sv
// Adjacency storage: per-node list head and tail memories with valid bits, and
// the edge link and target memories. Depends on dcf_pkg.
`default_nettype none

module dcf_graph_store
    import dcf_pkg::*;
#(
    parameter int MAX_NODES = 256,
    parameter int MAX_EDGES = 1024
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire dcf_store_cmd_t                      cmd,
    input  wire logic [$clog2(MAX_NODES+1)-1:0]      node_addr,
    input  wire logic [$clog2(MAX_NODES+1)-1:0]      head_addr,
    input  wire logic [$clog2(MAX_NODES+1)-1:0]      dst,
    input  wire logic [$clog2(MAX_EDGES)-1:0]        edge_addr,
    output logic      [$clog2(MAX_EDGES)-1:0]        head_q,
    output logic                                     head_hit_q,
    output logic      [$clog2(MAX_EDGES+1)-1:0]      next_q,
    output logic      [$clog2(MAX_NODES+1)-1:0]      target_q,
    output logic                                     full
);

    localparam int NW  = $clog2(MAX_NODES + 1);
    localparam int EAW = $clog2(MAX_EDGES);
    localparam int EW  = $clog2(MAX_EDGES + 1);
    localparam logic [EW-1:0] EDGE_NULL = EW'(MAX_EDGES);

    logic [EAW-1:0] head_mem [2**NW];
    logic [EAW-1:0] tail_mem [2**NW];
    logic [EW-1:0]  next_mem [MAX_EDGES];
    logic [NW-1:0]  target_mem [MAX_EDGES];
    logic [MAX_NODES:0] list_valid_reg;
    logic [EW-1:0]  count_reg;
    logic           link_pend_reg;
    logic [EAW-1:0] link_addr_reg;
    logic [EAW-1:0] link_data_reg;
    logic [EAW-1:0] new_edge;
    logic [EAW-1:0] tail_q;
    logic           tail_hit_q;

    assign new_edge = count_reg[EAW-1:0];
    assign full     = (count_reg == EW'(MAX_EDGES));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            list_valid_reg <= '0;
            count_reg      <= '0;
            link_pend_reg  <= 1'b0;
        end else begin
            link_pend_reg <= 1'b0;
            if (cmd.commit) begin
                list_valid_reg[node_addr] <= 1'b1;
                count_reg     <= count_reg + 1'b1;
                link_pend_reg <= tail_hit_q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            link_addr_reg <= tail_q;
            link_data_reg <= new_edge;
            tail_mem[node_addr] <= new_edge;
        end
        if (cmd.tail_rd) begin
            tail_q     <= tail_mem[node_addr];
            tail_hit_q <= list_valid_reg[node_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && !list_valid_reg[node_addr]) begin
            head_mem[node_addr] <= new_edge;
        end
        if (cmd.head_rd) begin
            head_q     <= head_mem[head_addr];
            head_hit_q <= list_valid_reg[head_addr];
        end
    end

    // The old tail is linked to the new edge in the cycle after the commit.
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            next_mem[new_edge] <= EDGE_NULL;
        end else if (link_pend_reg) begin
            next_mem[link_addr_reg] <= EW'(link_data_reg);
        end
        if (cmd.edge_rd) begin
            next_q <= next_mem[edge_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            target_mem[new_edge] <= dst;
        end
        if (cmd.edge_rd) begin
            target_q <= target_mem[edge_addr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/directed_cycle_finder.sv
// Add edge: tail read, commit, then link write and result. Read: a stack read, then
// the result. Rejected edge, empty read and unused opcode answer from idle. Run: a
// clearing pass over the node colors in use, then memory reads for each node
// visited and each edge examined. One item at a time; the result register
// frees the input side. Reset (aresetn low, synchronous) clears control state, the
// list valid bits and the edge count; each run clears the node colors it uses.
`default_nettype none

module directed_cycle_finder
    import dcf_pkg::*;
#(
    parameter int MAX_NODES = 256,
    parameter int MAX_EDGES = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [8:0]  cfg_wdata,     // node_count
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,       // src_node [8:0], dst_node [17:9], zero fill
    input  wire logic [1:0]  s_tuser,       // opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,       // cycle_length [8:0], node [17:9], zero fill
    output logic      [1:0]  m_tuser,       // status
    output logic             m_tlast        // last
);

    localparam int NW   = $clog2(MAX_NODES + 1);
    localparam int EAW  = $clog2(MAX_EDGES);
    localparam int EW   = $clog2(MAX_EDGES + 1);
    localparam int SW   = $clog2(MAX_NODES);
    localparam int CNTW = $clog2(MAX_NODES + 1);
    localparam int PW   = $clog2(MAX_NODES + 2);
    localparam int CW   = (NW > FIELD_W) ? NW : FIELD_W;
    localparam int SEW  = NW + EW;
    localparam logic [EW-1:0] EDGE_NULL = EW'(MAX_EDGES);

    localparam logic [1:0] COLOR_NEW  = 2'd0;
    localparam logic [1:0] COLOR_PATH = 2'd1;
    localparam logic [1:0] COLOR_DONE = 2'd2;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_ADD_WR    = 4'd1;
    localparam logic [3:0] S_ADD_LINK  = 4'd2;
    localparam logic [3:0] S_START     = 4'd3;
    localparam logic [3:0] S_START_W   = 4'd4;
    localparam logic [3:0] S_EDGE      = 4'd5;
    localparam logic [3:0] S_EDGE_W    = 4'd6;
    localparam logic [3:0] S_PUSH_W    = 4'd7;
    localparam logic [3:0] S_POP_W     = 4'd8;
    localparam logic [3:0] S_FOUND_W   = 4'd9;
    localparam logic [3:0] S_READ_W    = 4'd10;
    localparam logic [3:0] S_CLEAR     = 4'd11;
    localparam logic [3:0] S_COLOR_W   = 4'd12;

    logic [3:0]        state_reg, state_next;
    logic [8:0]        node_count_reg;
    logic              m_valid_reg, m_valid_next;
    dcf_result_t       result_reg, result_next;
    logic [NW-1:0]     src_reg, src_next;
    logic [NW-1:0]     dst_reg, dst_next;
    logic [CW:0]       start_reg, start_next;
    logic [NW-1:0]     top_u_reg, top_u_next;
    logic [EW-1:0]     top_e_reg, top_e_next;
    logic [CNTW-1:0]   sp_reg, sp_next;
    logic              found_reg, found_next;
    logic [SW-1:0]     base_reg, base_next;
    logic [CNTW-1:0]   count_reg, count_next;
    logic [PW-1:0]     pos_reg, pos_next;

    logic [SEW-1:0]    stack_mem [MAX_NODES];
    logic [SEW-1:0]    stack_q;
    logic [SW-1:0]     depth_mem [2**NW];
    logic [SW-1:0]     depth_q;
    logic [1:0]        color_mem [2**NW];
    logic [1:0]        color_q;

    logic              stack_we, stack_re;
    logic [SW-1:0]     stack_waddr, stack_raddr;
    logic [SEW-1:0]    stack_wdata;
    logic              depth_we, depth_re;
    logic [NW-1:0]     depth_addr;
    logic              color_we, color_re;
    logic [NW-1:0]     color_addr;
    logic [1:0]        color_wdata;

    dcf_store_cmd_t    cmd;
    logic [NW-1:0]     node_addr, head_addr;
    logic [EAW-1:0]    head_q;
    logic              head_hit_q;
    logic [EW-1:0]     next_q;
    logic [NW-1:0]     target_q;
    logic              store_full;

    logic [CW-1:0]     nc;
    logic [CW-1:0]     in_src, in_dst, v_cw;
    logic [NW-1:0]     start_node;
    logic [CNTW-1:0]   found_count;
    logic [CNTW:0]     len_full;
    logic              s_accept;

    dcf_graph_store #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .node_addr  (node_addr),
        .head_addr  (head_addr),
        .dst        (dst_reg),
        .edge_addr  (top_e_reg[EAW-1:0]),
        .head_q     (head_q),
        .head_hit_q (head_hit_q),
        .next_q     (next_q),
        .target_q   (target_q),
        .full       (store_full)
    );

    assign nc = (CW'(node_count_reg) > CW'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(node_count_reg);
    assign in_src     = CW'(s_tdata[8:0]);
    assign in_dst     = CW'(s_tdata[17:9]);
    assign v_cw       = CW'(target_q);
    assign start_node = NW'(start_reg);
    assign found_count = sp_reg - CNTW'(depth_q);
    assign len_full    = {1'b0, count_reg} + 1'b1;

    assign s_tready = (state_reg == S_IDLE) && (!m_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = result_reg.status;
    assign m_tlast  = result_reg.last;
    assign m_tdata  = {6'd0, result_reg.node, result_reg.cycle_length};

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        result_next  = result_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        start_next   = start_reg;
        top_u_next   = top_u_reg;
        top_e_next   = top_e_reg;
        sp_next      = sp_reg;
        found_next   = found_reg;
        base_next    = base_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        cmd          = '0;
        node_addr    = src_reg;
        head_addr    = start_node;
        stack_we     = 1'b0;
        stack_re     = 1'b0;
        stack_waddr  = SW'(sp_reg - 1'b1);
        stack_raddr  = SW'(sp_reg - 2'd2);
        stack_wdata  = {top_u_reg, next_q};
        depth_we     = 1'b0;
        depth_re     = 1'b0;
        depth_addr   = target_q;
        color_we     = 1'b0;
        color_re     = 1'b0;
        color_addr   = target_q;
        color_wdata  = COLOR_NEW;

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    result_next = '0;
                    case (s_tuser)
                        OP_ADD: begin
                            if (in_src == '0 || in_src > nc || in_dst == '0 || in_dst > nc
                                || store_full) begin
                                result_next.status = STATUS_REJECT;
                                m_valid_next = 1'b1;
                            end else begin
                                src_next  = NW'(in_src);
                                dst_next  = NW'(in_dst);
                                node_addr = NW'(in_src);
                                cmd.tail_rd = 1'b1;
                                state_next  = S_ADD_WR;
                            end
                        end
                        OP_RUN: begin
                            found_next   = 1'b0;
                            count_next   = '0;
                            pos_next     = '0;
                            sp_next      = '0;
                            start_next   = (CW+1)'(1);
                            state_next   = S_CLEAR;
                        end
                        OP_READ: begin
                            if (!found_reg || pos_reg > PW'(count_reg)) begin
                                result_next.status = STATUS_EMPTY;
                                m_valid_next = 1'b1;
                            end else begin
                                stack_re    = 1'b1;
                                stack_raddr = (pos_reg == PW'(count_reg)) ? base_reg
                                              : base_reg + pos_reg[SW-1:0];
                                state_next  = S_READ_W;
                            end
                        end
                        default: begin
                            result_next.status = STATUS_EMPTY;
                            m_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_ADD_WR: begin
                cmd.commit = 1'b1;
                state_next = S_ADD_LINK;
            end
            S_ADD_LINK: begin
                result_next  = '0;
                m_valid_next = 1'b1;
                state_next   = S_IDLE;
            end
            S_CLEAR: begin
                // Only nodes in use are ever looked at, so only those are cleared.
                if (start_reg > (CW+1)'(nc)) begin
                    start_next = (CW+1)'(1);
                    state_next = S_START;
                end else begin
                    color_we    = 1'b1;
                    color_addr  = start_node;
                    color_wdata = COLOR_NEW;
                    start_next  = start_reg + 1'b1;
                end
            end
            S_START: begin
                if (start_reg > (CW+1)'(nc)) begin
                    result_next        = '0;
                    result_next.status = STATUS_NONE;
                    m_valid_next       = 1'b1;
                    state_next         = S_IDLE;
                end else begin
                    cmd.head_rd = 1'b1;
                    color_re    = 1'b1;
                    color_addr  = start_node;
                    state_next  = S_START_W;
                end
            end
            S_START_W: begin
                if (color_q != COLOR_NEW) begin
                    start_next = start_reg + 1'b1;
                    state_next = S_START;
                end else begin
                    top_u_next  = start_node;
                    top_e_next  = head_hit_q ? EW'(head_q) : EDGE_NULL;
                    color_we    = 1'b1;
                    color_addr  = start_node;
                    color_wdata = COLOR_PATH;
                    depth_we    = 1'b1;
                    depth_addr  = start_node;
                    sp_next     = CNTW'(1);
                    state_next  = S_EDGE;
                end
            end
            S_EDGE: begin
                if (top_e_reg == EDGE_NULL) begin
                    // Node exhausted: retire it and pop back to its parent.
                    color_we    = 1'b1;
                    color_addr  = top_u_reg;
                    color_wdata = COLOR_DONE;
                    sp_next = sp_reg - 1'b1;
                    if (sp_reg == CNTW'(1)) begin
                        start_next = start_reg + 1'b1;
                        state_next = S_START;
                    end else begin
                        stack_re   = 1'b1;
                        state_next = S_POP_W;
                    end
                end else begin
                    cmd.edge_rd = 1'b1;
                    state_next  = S_EDGE_W;
                end
            end
            S_POP_W: begin
                top_u_next = stack_q[SEW-1:EW];
                top_e_next = stack_q[EW-1:0];
                state_next = S_EDGE;
            end
            S_EDGE_W: begin
                top_e_next = next_q;
                state_next = S_EDGE;
                if (v_cw != '0 && v_cw <= nc) begin
                    color_re   = 1'b1;
                    state_next = S_COLOR_W;
                end
            end
            S_COLOR_W: begin
                state_next = S_EDGE;
                if (color_q == COLOR_NEW) begin
                    if (sp_reg < CNTW'(MAX_NODES)) begin
                        stack_we    = 1'b1;
                        depth_we    = 1'b1;
                        color_we    = 1'b1;
                        color_wdata = COLOR_PATH;
                        head_addr   = target_q;
                        cmd.head_rd = 1'b1;
                        top_u_next  = target_q;
                        sp_next     = sp_reg + 1'b1;
                        state_next  = S_PUSH_W;
                    end
                end else if (color_q == COLOR_PATH) begin
                    // Back edge: the cycle is the stack from the target's depth up.
                    stack_we   = 1'b1;
                    depth_re   = 1'b1;
                    state_next = S_FOUND_W;
                end
            end
            S_PUSH_W: begin
                top_e_next = head_hit_q ? EW'(head_q) : EDGE_NULL;
                state_next = S_EDGE;
            end
            S_FOUND_W: begin
                base_next  = depth_q;
                count_next = found_count;
                found_next = 1'b1;
                result_next = '0;
                result_next.cycle_length = FIELD_W'({1'b0, found_count} + 1'b1);
                m_valid_next = 1'b1;
                state_next   = S_IDLE;
            end
            S_READ_W: begin
                result_next = '0;
                result_next.cycle_length = FIELD_W'(len_full);
                result_next.node = FIELD_W'(stack_q[SEW-1:EW]);
                result_next.last = (pos_reg == PW'(count_reg));
                pos_next     = pos_reg + 1'b1;
                m_valid_next = 1'b1;
                state_next   = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            node_count_reg <= 9'd256;
            m_valid_reg    <= 1'b0;
            found_reg      <= 1'b0;
            count_reg      <= '0;
            pos_reg        <= '0;
            sp_reg         <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            found_reg   <= found_next;
            count_reg   <= count_next;
            pos_reg     <= pos_next;
            sp_reg      <= sp_next;
            if (cfg_we) begin
                node_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
        src_reg    <= src_next;
        dst_reg    <= dst_next;
        start_reg  <= start_next;
        top_u_reg  <= top_u_next;
        top_e_reg  <= top_e_next;
        base_reg   <= base_next;
    end

    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        if (stack_re) begin
            stack_q <= stack_mem[stack_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (depth_we) begin
            depth_mem[depth_addr] <= SW'(sp_reg);
        end
        if (depth_re) begin
            depth_q <= depth_mem[depth_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (color_we) begin
            color_mem[color_addr] <= color_wdata;
        end
        if (color_re) begin
            color_q <= color_mem[color_addr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/dcf_checker.sv
// Port-level checks for directed_cycle_finder, attached by the bind below.
// Depends on dcf_pkg for the status codes.
`default_nettype none

module dcf_checker
    import dcf_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    // A stalled result must hold.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // After a transfer in, either a result is presented or the block is busy.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid || !s_tready)
        else $error("input taken with no result and no busy period");

    // Any status other than ok carries all-zero fields.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STATUS_OK |-> m_tdata == 24'd0 && !m_tlast)
        else $error("nonzero fields on a failed status");

    // The closing node of a read comes with a cycle length.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[8:0] != 9'd0 && m_tdata[17:9] != 9'd0)
        else $error("last transfer without cycle data");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind directed_cycle_finder dcf_checker u_dcf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

>>> tb/dcf_checker.sv
// Result checker for the directed cycle finder: watches both streams, predicts
// each result from its own graph and search state, and counts mismatches.
// Depends on dcf_pkg for operation and status codes.
`default_nettype none

module dcf_scoreboard
    import dcf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [8:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,
    input  wire logic [1:0]  m_tuser,
    input  wire logic        m_tlast,
    output int               fail_count,
    output int               pending
);

    localparam int NODES = 256;
    localparam int EDGES = 1024;
    localparam int NO_EDGE = EDGES;
    localparam int WHITE = 0;
    localparam int GREY = 1;
    localparam int BLACK = 2;

    int          nodes_in_use;
    int          head[NODES+1];
    int          tail[NODES+1];
    int          link[EDGES];
    int          target[EDGES];
    int          edge_total;
    int          color[NODES+1];
    int          parent[NODES+1];
    int          stk_node[NODES];
    int          stk_edge[NODES];
    int          loop_nodes[NODES];
    int          loop_len;
    int          read_pos;
    bit          have_loop;
    dcf_result_t expected_results[$];

    function automatic int limit_nodes();
        return nodes_in_use > NODES ? NODES : nodes_in_use;
    endfunction

    task automatic save_loop(input int from, input int to);
        int cur;
        int k;
        int t;
        cur = from;
        k = 0;
        while (cur != to && k < NODES - 1 && cur <= NODES) begin
            loop_nodes[k] = cur;
            k++;
            cur = parent[cur];
        end
        loop_nodes[k] = to;
        k++;
        loop_len = k;
        for (int i = 0; i < k / 2; i++) begin
            t = loop_nodes[i];
            loop_nodes[i] = loop_nodes[k-1-i];
            loop_nodes[k-1-i] = t;
        end
        have_loop = 1;
    endtask

    task automatic search_cycle();
        int nc;
        int sp;
        int u;
        int e;
        int v;
        nc = limit_nodes();
        foreach (color[i]) color[i] = WHITE;
        have_loop = 0;
        loop_len = 0;
        read_pos = 0;
        for (int s = 1; s <= nc && !have_loop; s++) begin
            if (color[s] != WHITE) continue;
            sp = 0;
            parent[s] = 0;
            color[s] = GREY;
            stk_node[0] = s;
            stk_edge[0] = head[s];
            sp = 1;
            while (sp > 0 && !have_loop) begin
                u = stk_node[sp-1];
                e = stk_edge[sp-1];
                if (e >= NO_EDGE) begin
                    color[u] = BLACK;
                    sp--;
                    continue;
                end
                stk_edge[sp-1] = link[e];
                v = target[e];
                if (v < 1 || v > nc) continue;
                if (color[v] == WHITE) begin
                    if (sp >= NODES) continue;
                    parent[v] = u;
                    color[v] = GREY;
                    stk_node[sp] = v;
                    stk_edge[sp] = head[v];
                    sp++;
                end else if (color[v] == GREY) begin
                    save_loop(u, v);
                end
            end
        end
    endtask

    task automatic predict_item(input logic [1:0] op, input int src, input int dst);
        dcf_result_t r;
        int nc;
        r = '0;
        nc = limit_nodes();
        if (op == OP_ADD) begin
            if (src < 1 || src > nc || dst < 1 || dst > nc || edge_total >= EDGES) begin
                r.status = STATUS_REJECT;
            end else begin
                target[edge_total] = dst;
                link[edge_total] = NO_EDGE;
                if (tail[src] >= NO_EDGE) head[src] = edge_total;
                else link[tail[src]] = edge_total;
                tail[src] = edge_total;
                edge_total++;
            end
        end else if (op == OP_RUN) begin
            search_cycle();
            if (have_loop) r.cycle_length = 9'(loop_len + 1);
            else r.status = STATUS_NONE;
        end else if (op == OP_READ) begin
            if (!have_loop || loop_len == 0 || read_pos > loop_len) begin
                r.status = STATUS_EMPTY;
            end else begin
                r.cycle_length = 9'(loop_len + 1);
                if (read_pos < loop_len) begin
                    r.node = 9'(loop_nodes[read_pos]);
                end else begin
                    r.node = 9'(loop_nodes[0]);
                    r.last = 1'b1;
                end
                read_pos++;
            end
        end else begin
            r.status = STATUS_EMPTY;
        end
        expected_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        dcf_result_t want;
        if (!aresetn) begin
            fail_count = 0;
            nodes_in_use = 256;
            for (int i = 0; i <= NODES; i++) begin
                head[i] = NO_EDGE;
                tail[i] = NO_EDGE;
            end
            edge_total = 0;
            loop_len = 0;
            read_pos = 0;
            have_loop = 0;
            expected_results.delete();
        end else begin
            // The result side is checked first, since the block answers in the cycle
            // after it takes an item at the earliest.
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result transfer with nothing expected");
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (m_tuser !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_tuser, want.status));
                    if (m_tdata[8:0] !== want.cycle_length)
                        report_mismatch($sformatf("cycle_length %0d, expected %0d",
                                                  m_tdata[8:0], want.cycle_length));
                    if (m_tdata[17:9] !== want.node)
                        report_mismatch($sformatf("node %0d, expected %0d",
                                                  m_tdata[17:9], want.node));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  m_tlast, want.last));
                end
            end
            if (cfg_we) nodes_in_use = int'(cfg_wdata);
            if (s_tvalid && s_tready)
                predict_item(s_tuser, int'(s_tdata[8:0]), int'(s_tdata[17:9]));
        end
        pending = expected_results.size();
    end

endmodule

`default_nettype wire

>>> tb/tb_directed_cycle_finder.sv
// Testbench top for directed_cycle_finder: drives edge loads, searches and reads
// under several node counts and idle patterns. Depends on dcf_pkg, directed_cycle_finder and dcf_scoreboard.
`default_nettype none

module tb_directed_cycle_finder
    import dcf_pkg::*;
();

    localparam int CYCLE_LIMIT = 3000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [8:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          cycle_count = 0;
    int          node_span;

    always #10 aclk = ~aclk;

    directed_cycle_finder u_top (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    dcf_scoreboard u_checker (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast), .fail_count(fail_count), .pending(pending)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("directed_cycle_finder verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // One transfer on the input side; optional random idle cycles first.
    task automatic send_item(input logic [1:0] op, input logic [8:0] src,
                             input logic [8:0] dst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {6'd0, dst, src};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        // Every search has ended with its result by now; the wait adds idle time.
        repeat (4000) @(posedge aclk);
    endtask

    task automatic set_nodes(input int count);
        cfg_we <= 1'b1;
        cfg_wdata <= 9'(count);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [8:0] pick_node();
        int r;
        r = $urandom_range(99);
        if (r < 4) return 9'($urandom_range(511));
        if (r < 8) return 9'd0;
        return 9'($urandom_range(node_span, 1));
    endfunction

    // A round of traffic: edge adds, some with out-of-range nodes, a search, then reads that may run past the end.
    task automatic graph_round(output int n_sent);
        int n_edges;
        int n_reads;
        n_edges = $urandom_range(8, 1);
        n_reads = $urandom_range(10, 1);
        n_sent = n_edges + 1 + n_reads;
        for (int i = 0; i < n_edges; i++)
            send_item(OP_ADD, pick_node(), pick_node());
        send_item(OP_RUN, 9'($urandom), 9'($urandom));
        repeat (n_reads) send_item(OP_READ, 9'($urandom), 9'($urandom));
        if ($urandom_range(19) == 0) begin
            send_item(OP_UNUSED, 9'($urandom), 9'($urandom));
            n_sent++;
        end
    endtask

    task automatic random_phase(input int count, input int nodes, input int span);
        int sent;
        int n;
        drain();
        set_nodes(nodes);
        node_span = span;
        sent = 0;
        while (sent < count) begin
            graph_round(n);
            sent += n;
        end
    endtask

    initial begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: a three-node cycle, bad edges and reads around it.
        send_item(OP_READ, 9'd0, 9'd0);
        send_item(OP_RUN, 9'd0, 9'd0);
        send_item(OP_ADD, 9'd1, 9'd2);
        send_item(OP_ADD, 9'd2, 9'd3);
        send_item(OP_ADD, 9'd3, 9'd1);
        send_item(OP_ADD, 9'd0, 9'd5);
        send_item(OP_ADD, 9'd5, 9'd0);
        send_item(OP_ADD, 9'd257, 9'd4);
        send_item(OP_ADD, 9'd511, 9'd511);
        send_item(OP_ADD, 9'd256, 9'd256);
        send_item(OP_RUN, 9'd0, 9'd0);
        repeat (5) send_item(OP_READ, 9'h1ff, 9'h1ff);
        send_item(OP_UNUSED, 9'h1ff, 9'h1ff);
        drain();
        // Lowering the count leaves the 256 self loop and the triangle stale.
        set_nodes(2);
        send_item(OP_RUN, 9'd0, 9'd0);
        send_item(OP_ADD, 9'd2, 9'd1);
        send_item(OP_RUN, 9'd0, 9'd0);
        repeat (4) send_item(OP_READ, 9'd0, 9'd0);
        drain();
        set_nodes(0);
        send_item(OP_RUN, 9'd0, 9'd0);
        send_item(OP_ADD, 9'd1, 9'd1);
        send_item(OP_READ, 9'd0, 9'd0);
        drain();
        set_nodes(1);
        send_item(OP_ADD, 9'd1, 9'd1);
        send_item(OP_RUN, 9'd0, 9'd0);
        repeat (3) send_item(OP_READ, 9'd0, 9'd0);

        send_idle_pct = 23;
        recv_idle_pct = 65;
        random_phase(350, 256, 256);
        random_phase(300, 12, 12);
        send_idle_pct = 65;
        recv_idle_pct = 23;
        random_phase(300, 300, 20);
        random_phase(300, 1, 1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(350, 256, 40);
        random_phase(350, 6, 7);

        drain();
        if (fail_count == 0) begin
            $display("directed_cycle_finder verification clean");
        end else begin
            $display("directed_cycle_finder verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
